>>> sv/tbpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Background pixel fetch package
// Shared types, command codes, register indexes and address constants.
// ----------------------------------------------------------------------------
package tbpf_pkg;

	// Video memory is split into an even-byte bank and an odd-byte bank.
	localparam int VRAM_BYTES        = 8192;
	localparam int MAP_TILES_PER_ROW = 32;
	localparam int ADDR_W            = $clog2(VRAM_BYTES);
	localparam int WORD_ADDR_W       = ADDR_W - 1;
	localparam int BANK_WORDS        = VRAM_BYTES / 2;

	// Request function codes.
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_RENDER = 1'b1;

	// Command kinds handed from the front to the back.
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_RENDER = 2'd1;
	localparam logic [1:0] CMD_BLANK  = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_BG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_TILE_SELECT = 3'd1;
	localparam logic [2:0] REG_MAP_SELECT  = 3'd2;
	localparam logic [2:0] REG_SCROLL_X    = 3'd3;
	localparam logic [2:0] REG_SCROLL_Y    = 3'd4;
	localparam logic [2:0] REG_BG_PALETTE  = 3'd5;

	// Tile maps sit at 0x1800 and 0x1C00: the top two address bits are set.
	localparam logic [1:0] MAP_BASE_TOP = 2'b11;
	// Pattern data base 0x0800 expressed as a 16-bit word address.
	localparam logic [WORD_ADDR_W-1:0] DATA_BASE_LOW_WORD = 12'h400;

	// Color index forced when the background is switched off.
	localparam logic [1:0] BLANK_COLOR = 2'd3;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic       bg_enable;
		logic       tile_data_select;
		logic       map_select;
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;
		logic [7:0] bg_palette;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;     // write address or tile map address
		logic [7:0]        data;     // write byte
		logic [2:0]        row;      // row inside the tile
		logic [2:0]        pix;      // column inside the tile
		logic              data_sel; // pattern base select
	} cmd_t;

endpackage : tbpf_pkg
`default_nettype wire

>>> sv/tile_background_pixel_fetch_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tile background pixel fetch unit
// Holds an 8 KB video memory and turns screen positions into background
// color indexes and palette shades.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Carries
//  req       req_valid/req_ready   func, mem_addr, write_data, screen_x, screen_y
//  pix       pix_valid/pix_ready   color_index, shade
//  cfg       APB psel/penable      six control registers at byte address 4*i
//
//  A write request finishes at dispatch. A render request makes two reads:
//  a tile map read and a dependent pattern row read, both from the one port of the
//  banked video memory, which sets the rate. A render with the background off reads
//  no memory. Reset clears the registers and the control state; video memory
//  content is undefined until written. A stalled pix channel holds one finished
//  pixel while the queue keeps taking up to two more requests.
// ----------------------------------------------------------------------------
module tile_background_pixel_fetch_unit
	import tbpf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic              func,
	input  wire logic [ADDR_W-1:0] mem_addr,
	input  wire logic [7:0]        write_data,
	input  wire logic [7:0]        screen_x,
	input  wire logic [7:0]        screen_y,

	output logic                   pix_valid,
	input  wire logic              pix_ready,
	output logic [1:0]             color_index,
	output logic [1:0]             shade,

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [4:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	cfg_t       cfg_q;
	logic [2:0] reg_index;
	logic       cfg_write;

	cmd_t       front_cmd;
	logic       queue_full;
	logic       push;
	logic       pop;
	logic       head_valid;
	cmd_t       head_cmd;

	// Register file. Each register sits at a 4-byte aligned address; writes to
	// unused addresses are dropped.
	assign pready    = 1'b1;
	assign reg_index = paddr[4:2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (reg_index)
				REG_BG_ENABLE:   cfg_q.bg_enable        <= pwdata[0];
				REG_TILE_SELECT: cfg_q.tile_data_select <= pwdata[0];
				REG_MAP_SELECT:  cfg_q.map_select       <= pwdata[0];
				REG_SCROLL_X:    cfg_q.scroll_x         <= pwdata[7:0];
				REG_SCROLL_Y:    cfg_q.scroll_y         <= pwdata[7:0];
				REG_BG_PALETTE:  cfg_q.bg_palette       <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_BG_ENABLE:   prdata = {31'd0, cfg_q.bg_enable};
			REG_TILE_SELECT: prdata = {31'd0, cfg_q.tile_data_select};
			REG_MAP_SELECT:  prdata = {31'd0, cfg_q.map_select};
			REG_SCROLL_X:    prdata = {24'd0, cfg_q.scroll_x};
			REG_SCROLL_Y:    prdata = {24'd0, cfg_q.scroll_y};
			REG_BG_PALETTE:  prdata = {24'd0, cfg_q.bg_palette};
			default:         prdata = '0;
		endcase
	end

	// The front accepts whenever the queue has room, independent of how far
	// the back end has got.
	assign req_ready = !queue_full;
	assign push      = req_valid && req_ready;

	tbpf_front u_front (
		.func       (func),
		.mem_addr   (mem_addr),
		.write_data (write_data),
		.screen_x   (screen_x),
		.screen_y   (screen_y),
		.cfg        (cfg_q),
		.cmd        (front_cmd)
	);

	tbpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (front_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	tbpf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.bg_palette  (cfg_q.bg_palette),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.color_index (color_index),
		.shade       (shade)
	);

endmodule : tile_background_pixel_fetch_unit
`default_nettype wire

>>> sv/tbpf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Background pixel fetch front
// Classifies a request and works out the scrolled tile map address.
// ----------------------------------------------------------------------------
module tbpf_front
	import tbpf_pkg::*;
(
	input  wire logic              func,
	input  wire logic [ADDR_W-1:0] mem_addr,
	input  wire logic [7:0]        write_data,
	input  wire logic [7:0]        screen_x,
	input  wire logic [7:0]        screen_y,
	input  wire cfg_t              cfg,
	output cmd_t                   cmd
);

	logic [7:0] bx;
	logic [7:0] by;

	// Scroll wraps around the 256 by 256 background.
	assign bx = screen_x + cfg.scroll_x;
	assign by = screen_y + cfg.scroll_y;

	always_comb begin
		cmd.data     = write_data;
		cmd.row      = by[2:0];
		cmd.pix      = bx[2:0];
		cmd.data_sel = cfg.tile_data_select;
		if (func == FUNC_WRITE) begin
			cmd.kind = CMD_WRITE;
			cmd.addr = mem_addr;
		end else begin
			cmd.kind = cfg.bg_enable ? CMD_RENDER : CMD_BLANK;
			cmd.addr = {MAP_BASE_TOP, cfg.map_select, by[7:3], bx[7:3]};
		end
	end

endmodule : tbpf_front
`default_nettype wire

>>> sv/tbpf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Background pixel fetch command queue
// Two-entry queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module tbpf_queue
	import tbpf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output cmd_t      head_cmd
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t               entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign full       = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue pushed while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");
`endif

endmodule : tbpf_queue
`default_nettype wire

>>> sv/tbpf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Background pixel fetch back
// Owns the banked video memory, runs the map and pattern reads of a render
// and holds the output register.
// ----------------------------------------------------------------------------
module tbpf_back
	import tbpf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  wire cmd_t       head_cmd,
	output logic            pop,
	input  wire logic [7:0] bg_palette,
	output logic            pix_valid,
	input  wire logic       pix_ready,
	output logic [1:0]      color_index,
	output logic [1:0]      shade
);

	localparam logic [1:0] ST_DISPATCH = 2'd0;
	localparam logic [1:0] ST_MAP      = 2'd1;
	localparam logic [1:0] ST_PAT      = 2'd2;

	logic [1:0]             state_q;
	logic [1:0]             state_d;

	// Even and odd byte banks, one port each, shared address.
	logic [7:0]             even_mem [BANK_WORDS];
	logic [7:0]             odd_mem  [BANK_WORDS];
	logic [7:0]             even_rd_q;
	logic [7:0]             odd_rd_q;
	logic [WORD_ADDR_W-1:0] mem_addr;
	logic                   mem_re;
	logic                   we_even;
	logic                   we_odd;

	// Fields of the render in flight.
	logic [2:0]             row_q;
	logic [2:0]             pix_q;
	logic                   sel_q;
	logic                   lsb_q;

	logic                   out_free;
	logic                   can_dispatch;
	logic                   dispatch;
	logic                   is_render;
	logic                   is_blank;
	logic                   is_write;
	logic [7:0]             tile;
	logic [WORD_ADDR_W-1:0] pat_word;
	logic [2:0]             bit_pos;
	logic [1:0]             pat_color;
	logic                   load_pat;
	logic                   load_blank;
	logic [1:0]             load_color;

	logic                   pix_valid_q;
	logic [1:0]             color_q;
	logic [1:0]             shade_q;

	assign out_free  = !pix_valid_q || pix_ready;
	assign is_render = (head_cmd.kind == CMD_RENDER);
	assign is_blank  = (head_cmd.kind == CMD_BLANK);
	assign is_write  = (head_cmd.kind == CMD_WRITE);

	// A new write or render may start while the previous render finishes its output.
	assign can_dispatch = (state_q == ST_DISPATCH) || ((state_q == ST_PAT) && out_free);
	assign dispatch     = can_dispatch && head_valid &&
		(!is_blank || ((state_q == ST_DISPATCH) && out_free));
	assign pop          = dispatch;

	// Pattern row address: base + 8 * tile + row, in words.
	assign tile     = lsb_q ? odd_rd_q : even_rd_q;
	assign pat_word = {1'b0, tile, row_q} + (sel_q ? '0 : DATA_BASE_LOW_WORD);

	// The first pattern byte sits in the even bank and gives the high bit.
	assign bit_pos   = 3'd7 - pix_q;
	assign pat_color = {even_rd_q[bit_pos], odd_rd_q[bit_pos]};

	assign load_pat   = (state_q == ST_PAT) && out_free;
	assign load_blank = dispatch && is_blank;
	assign load_color = load_pat ? pat_color : BLANK_COLOR;

	always_comb begin
		mem_re   = 1'b0;
		we_even  = 1'b0;
		we_odd   = 1'b0;
		mem_addr = head_cmd.addr[ADDR_W-1:1];
		if (state_q == ST_MAP) begin
			mem_re   = 1'b1;
			mem_addr = pat_word;
		end else if (dispatch) begin
			mem_re  = is_render;
			we_even = is_write && !head_cmd.addr[0];
			we_odd  = is_write && head_cmd.addr[0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_DISPATCH: begin
				if (dispatch && is_render) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				state_d = ST_PAT;
			end
			ST_PAT: begin
				if (out_free) begin
					state_d = (dispatch && is_render) ? ST_MAP : ST_DISPATCH;
				end
			end
			default: begin
				state_d = ST_DISPATCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DISPATCH;
			pix_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_pat || load_blank) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_pat || load_blank) begin
			color_q <= load_color;
			shade_q <= 2'(bg_palette >> {load_color, 1'b0});
		end
		if (dispatch && is_render) begin
			row_q <= head_cmd.row;
			pix_q <= head_cmd.pix;
			sel_q <= head_cmd.data_sel;
			lsb_q <= head_cmd.addr[0];
		end
	end

	always_ff @(posedge clk) begin
		if (we_even) begin
			even_mem[mem_addr] <= head_cmd.data;
		end
		if (mem_re) begin
			even_rd_q <= even_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_odd) begin
			odd_mem[mem_addr] <= head_cmd.data;
		end
		if (mem_re) begin
			odd_rd_q <= odd_mem[mem_addr];
		end
	end

	assign pix_valid   = pix_valid_q;
	assign color_index = color_q;
	assign shade       = shade_q;

`ifndef ASSERT_OFF
	a_map_then_pat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAP) |=> (state_q == ST_PAT))
		else $error("map read not followed by pattern read");
	a_one_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(we_even && we_odd) && !(mem_re && (we_even || we_odd)))
		else $error("memory port used twice in one cycle");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((load_pat || load_blank) && pix_valid_q) |-> pix_ready)
		else $error("output register overwritten before it was taken");
	a_blank_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_blank |-> (state_q == ST_DISPATCH))
		else $error("blank pixel dispatched during a render");
`endif

endmodule : tbpf_back
`default_nettype wire

>>> bench/tile_background_pixel_fetch_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile background pixel fetch unit testbench
// Drives memory writes and pixel render requests through the req channel and
// sets up the six control registers over APB between phases. A scoreboard
// keeps its own copy of video memory and registers, predicts every pixel, and
// compares color index and shade of each returned pixel in order.
// ----------------------------------------------------------------------------
module tile_background_pixel_fetch_unit_tb
	import tbpf_pkg::*;
();

	// Map and pattern bases seen by the scoreboard, picked by the select bits.
	localparam logic [ADDR_W-1:0] MAP_BASE_SEL0  = 13'h1800;
	localparam logic [ADDR_W-1:0] MAP_BASE_SEL1  = 13'h1C00;
	localparam logic [ADDR_W-1:0] DATA_BASE_SEL0 = 13'h0800;
	localparam logic [ADDR_W-1:0] DATA_BASE_SEL1 = 13'h0000;

	// Register slots past the last real register; writes there must be ignored.
	localparam logic [2:0] REG_UNUSED_LO = 3'd6;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;

	// A write request leaves no pixel behind, so after the last pixel the back end
	// may still be busy with a trailing write. The drain wait below covers that easily.
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 1400;
	localparam int PHASE_ITEMS  = 175;
	localparam int CYCLE_LIMIT  = 1_000_000;

	typedef struct packed {
		logic [1:0] color;
		logic [1:0] shade;
	} pixel_t;

	// The scoreboard mirrors video memory and the registers. It turns every
	// accepted render request into the pixel the block should return.
	class bg_pixel_scoreboard;
		bit [7:0]    vram_copy [VRAM_BYTES];
		bit          written   [VRAM_BYTES];
		bit          bg_on;
		bit          data_sel;
		bit          map_sel;
		bit [7:0]    scroll_x_q;
		bit [7:0]    scroll_y_q;
		bit [7:0]    palette_q;
		pixel_t      pending_pixels [$];
		int unsigned errors;
		int unsigned renders;
		int unsigned blank_renders;
		int unsigned writes;

		function void apply_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_BG_ENABLE:   bg_on      = value[0];
				REG_TILE_SELECT: data_sel   = value[0];
				REG_MAP_SELECT:  map_sel    = value[0];
				REG_SCROLL_X:    scroll_x_q = value[7:0];
				REG_SCROLL_Y:    scroll_y_q = value[7:0];
				REG_BG_PALETTE:  palette_q  = value[7:0];
				default: ;
			endcase
		endfunction

		// Address of the map entry that covers a screen position.
		function logic [ADDR_W-1:0] map_addr(logic [7:0] x, logic [7:0] y);
			logic [7:0] bx;
			logic [7:0] by;
			bx = x + scroll_x_q;
			by = y + scroll_y_q;
			return (map_sel ? MAP_BASE_SEL1 : MAP_BASE_SEL0) + ADDR_W'({by[7:3], bx[7:3]});
		endfunction

		// Address of the first pattern byte of the tile row under a position.
		// The tile index is taken unsigned under both data bases.
		function logic [ADDR_W-1:0] row_addr(logic [7:0] x, logic [7:0] y);
			logic [7:0] by;
			logic [7:0] tile;
			by   = y + scroll_y_q;
			tile = vram_copy[map_addr(x, y)];
			return (data_sel ? DATA_BASE_SEL1 : DATA_BASE_SEL0) + ADDR_W'({tile, 4'b0000})
				+ ADDR_W'({by[2:0], 1'b0});
		endfunction

		function pixel_t predict_pixel(logic [7:0] x, logic [7:0] y);
			pixel_t            p;
			logic [7:0]        bx;
			logic [7:0]        first;
			logic [7:0]        second;
			logic [ADDR_W-1:0] ra;
			logic [2:0]        pos;
			if (!bg_on) begin
				p.color = BLANK_COLOR;
			end else begin
				bx     = x + scroll_x_q;
				ra     = row_addr(x, y);
				first  = vram_copy[ra];
				second = vram_copy[ra + 1'b1];
				pos    = 3'd7 - bx[2:0];
				// The first byte of the row gives the high bit of the index.
				p.color = {first[pos], second[pos]};
			end
			p.shade = palette_q[{p.color, 1'b0} +: 2];
			return p;
		endfunction

		function void note_request(logic f, logic [ADDR_W-1:0] a, logic [7:0] d,
				logic [7:0] x, logic [7:0] y);
			if (f == FUNC_WRITE) begin
				vram_copy[a] = d;
				written[a]   = 1'b1;
				writes++;
			end else begin
				pending_pixels.push_back(predict_pixel(x, y));
				renders++;
				if (!bg_on)
					blank_renders++;
			end
		endfunction

		function void check_pixel(logic [1:0] got_color, logic [1:0] got_shade);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				$error("pixel with none expected: color_index %0d shade %0d",
					got_color, got_shade);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (got_color !== want.color) begin
					$error("color_index: expected %0d, actual %0d", want.color, got_color);
					errors++;
				end
				if (got_shade !== want.shade) begin
					$error("shade: expected %0d, actual %0d", want.shade, got_shade);
					errors++;
				end
			end
		endfunction
	endclass

	// Every input of the block starts at a known value.
	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              req_valid   = 1'b0;
	logic              req_ready;
	logic              func        = FUNC_WRITE;
	logic [ADDR_W-1:0] mem_addr    = '0;
	logic [7:0]        write_data  = '0;
	logic [7:0]        screen_x    = '0;
	logic [7:0]        screen_y    = '0;
	logic              pix_valid;
	logic              pix_ready   = 1'b0;
	logic [1:0]        color_index;
	logic [1:0]        shade;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [4:0]        paddr       = '0;
	logic [31:0]       pwdata      = '0;
	logic [31:0]       prdata;
	logic              pready;

	bg_pixel_scoreboard sb;
	int unsigned        cycles      = 0;
	int unsigned        ready_mode  = 0;
	int unsigned        burst_left  = 0;
	int unsigned        items_sent  = 0;
	int unsigned        settings    = 0;

	tile_background_pixel_fetch_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.func        (func),
		.mem_addr    (mem_addr),
		.write_data  (write_data),
		.screen_x    (screen_x),
		.screen_y    (screen_y),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.color_index (color_index),
		.shade       (shade),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #5 clk = ~clk;

	// The cycle counter doubles as the watchdog. It is updated with a
	// nonblocking assignment so the stall pattern below reads a stable value.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d pixels outstanding",
				cycles, sb.pending_pixels.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// The pixel side stalls in one of four patterns, drawn at random:
	// always ready, coin flips, a fixed 2-of-5 duty cycle, and long runs of
	// ready or stall that hold a finished pixel while the queue fills behind it.
	always @(posedge clk) begin
		if (cycles % 200 == 0)
			ready_mode <= $urandom_range(0, 3);
		case (ready_mode)
			0: pix_ready <= 1'b1;
			1: pix_ready <= 1'($urandom_range(0, 1));
			2: pix_ready <= (cycles % 5) < 2;
			default: pix_ready <= ($urandom_range(0, 15) == 0) ? ~pix_ready : pix_ready;
		endcase
	end

	// Outputs are sampled at the edge, before the block's own updates land.
	always @(posedge clk) begin
		if (arst_n && pix_valid && pix_ready)
			sb.check_pixel(color_index, shade);
	end

	// Sends one request. The sender works in bursts; before each burst it may
	// drop valid for a random gap. Valid is never lowered between two requests
	// of one burst, so a new request never lowers and raises it in one step.
	task automatic issue(input logic f, input logic [ADDR_W-1:0] a, input logic [7:0] d,
			input logic [7:0] x, input logic [7:0] y);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// Now and then a long burst gives a stretch with no idling at all.
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
		burst_left--;
		req_valid  <= 1'b1;
		func       <= f;
		mem_addr   <= a;
		write_data <= d;
		screen_x   <= x;
		screen_y   <= y;
		do @(posedge clk); while (!req_ready);
		sb.note_request(f, a, d, x, y);
		items_sent++;
	endtask

	// A write request; the unused render fields carry random values.
	task automatic write_byte(input logic [ADDR_W-1:0] a, input logic [7:0] d);
		issue(FUNC_WRITE, a, d, 8'($urandom), 8'($urandom));
	endtask

	// A render request. When the background is on, any map or pattern byte the
	// pixel depends on that was never written is first filled with a random
	// byte, so no render ever reads undefined memory.
	task automatic render_at(input logic [7:0] x, input logic [7:0] y);
		logic [ADDR_W-1:0] a;
		if (sb.bg_on) begin
			a = sb.map_addr(x, y);
			if (!sb.written[a])
				write_byte(a, 8'($urandom));
			a = sb.row_addr(x, y);
			if (!sb.written[a])
				write_byte(a, 8'($urandom));
			if (!sb.written[a + 1'b1])
				write_byte(a + 1'b1, 8'($urandom));
		end
		issue(FUNC_RENDER, ADDR_W'($urandom), 8'($urandom), x, y);
	endtask

	// Stops the sender and waits until every pixel is back and the back end
	// has had time to finish any trailing write.
	task automatic drain();
		req_valid  <= 1'b0;
		burst_left = 0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One APB write. The bits above the register's width are random, since the
	// block must ignore them. psel stays up between back-to-back writes; the
	// caller drops it with apb_idle.
	task automatic apb_write(input logic [2:0] idx, input logic [7:0] value, input int bits);
		logic [31:0] word;
		word = $urandom;
		word = (word << bits) | 32'(value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.apply_reg(idx, word);
	endtask

	task automatic apb_idle();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Writes all six registers once the block has gone quiet.
	task automatic configure(input logic bg, input logic ts, input logic ms,
			input logic [7:0] sx, input logic [7:0] sy, input logic [7:0] pal);
		drain();
		apb_write(REG_BG_ENABLE, 8'(bg), 1);
		apb_write(REG_TILE_SELECT, 8'(ts), 1);
		apb_write(REG_MAP_SELECT, 8'(ms), 1);
		apb_write(REG_SCROLL_X, sx, 8);
		apb_write(REG_SCROLL_Y, sy, 8);
		apb_write(REG_BG_PALETTE, pal, 8);
		apb_idle();
		settings++;
	endtask

	initial begin : main
		logic [7:0]  x;
		logic [7:0]  y;
		int unsigned kind;
		int unsigned phase_end;
		int unsigned random_base;
		int unsigned phase;

		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Right after reset the background is off and the
		// palette is zero: renders give index 3 and read no memory at all.
		issue(FUNC_RENDER, '0, 8'h00, 8'h00, 8'h00);
		issue(FUNC_RENDER, '1, 8'hFF, 8'hFF, 8'hFF);
		write_byte('0, 8'h00);
		write_byte('1, 8'hFF);

		// Tile 0 at map entry 0, pattern base 0. The row bytes 0xA5 and 0x3C
		// give indexes 2, 0, 3, 1 in the first four columns, and the palette
		// 0xE4 maps each index to itself.
		configure(1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'hE4);
		write_byte(MAP_BASE_SEL0, 8'h00);
		write_byte(13'h0000, 8'hA5);
		write_byte(13'h0001, 8'h3C);
		for (int i = 0; i < 4; i++)
			render_at(8'(i), 8'h00);
		render_at(8'h07, 8'h00);

		// Both scrolls at their largest value wrap around the background, and
		// the last entry of the upper map holds tile 255 on the 0x0800 base.
		configure(1'b1, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'h1B);
		write_byte(MAP_BASE_SEL1 + 13'h03FF, 8'hFF);
		render_at(8'h00, 8'h00);
		render_at(8'hFF, 8'hFF);

		// Writes to the two unused register slots must change nothing.
		drain();
		apb_write(REG_UNUSED_LO, 8'($urandom), 8);
		apb_write(REG_UNUSED_HI, 8'($urandom), 8);
		apb_idle();
		render_at(8'h80, 8'h40);

		// Background off again with a palette whose top shade is black.
		configure(1'b0, 1'b0, 1'b1, 8'h12, 8'h34, 8'hC0);
		render_at(8'h00, 8'h00);
		render_at(8'h5A, 8'hA5);

		// Random part, in phases. The first phase puts each register but the enable
		// at its low end, the second at its high end, the rest draw at random with
		// the background mostly on. Renders dominate; their dependencies are
		// filled on demand, and plain writes scribble over memory as noise.
		random_base = items_sent;
		phase = 0;
		while (items_sent - random_base < RANDOM_ITEMS) begin
			case (phase)
				0: configure(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
				1: configure(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF);
				default: configure($urandom_range(0, 6) != 0, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				kind = $urandom_range(0, 99);
				if (kind < 55) begin
					render_at(8'($urandom), 8'($urandom));
				end else if (kind < 65) begin
					// A sweep across eight neighbouring columns walks every
					// bit position of a pattern row.
					x = 8'($urandom);
					y = 8'($urandom);
					for (int i = 0; i < 8; i++)
						render_at(8'(x + i), y);
				end else begin
					write_byte(ADDR_W'($urandom), 8'($urandom));
				end
			end
			phase++;
		end

		drain();
		$display("Covered %0d pixel renders, %0d of them with the background off, and %0d",
			sb.renders, sb.blank_renders, sb.writes);
		$display("video memory writes over %0d register settings.", settings);
		if (sb.errors == 0 && sb.pending_pixels.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
sv/tbpf_pkg.sv
sv/tbpf_front.sv
sv/tbpf_queue.sv
sv/tbpf_back.sv
sv/tile_background_pixel_fetch_unit.sv
bench/tile_background_pixel_fetch_unit_tb.sv
